@@ src/descriptor_slot_allocator_assert.svh @@
// Assertion macros shared by the descriptor slot allocator RTL
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication
`define DSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("descriptor_slot_allocator: assertion failed");
// Next-cycle implication
`define DSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("descriptor_slot_allocator: assertion failed");
`else
`define DSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/dsa_pkg.sv @@
// Shared constants and types for the descriptor slot allocator
package dsa_pkg;

  localparam int MAX_SLOTS    = 1024;
  localparam int IDX_W        = $clog2(MAX_SLOTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ADDR_W       = 64;
  localparam int STEP_W       = 13;
  localparam int SLOT_COUNT_W = 11;
  localparam int DIGIT_W      = 4;
  localparam int NUM_DIGITS   = ADDR_W / DIGIT_W;
  localparam int DCNT_W       = $clog2(NUM_DIGITS);
  localparam int PROD_W       = IDX_W + STEP_W;
  localparam int CFG_IDX_W    = 2;
  localparam int STATUS_W     = 3;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(32);

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPU_BASE   = 2'd0,
    CFG_GPU_BASE   = 2'd1,
    CFG_SLOT_STEP  = 2'd2,
    CFG_SLOT_COUNT = 2'd3
  } cfg_reg_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_RANGE    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Control for one digit-serial lane
  typedef struct packed {
    logic load;
    logic run;
  } lane_ctl_t;

endpackage

@@ src/descriptor_slot_allocator.sv @@
// Top level: LIFO free-slot allocator with digit-serial address arithmetic
// Allocate: a RAM read, a multiply, then a digit-serial add of the base and index times step;
// allocate on an empty stack goes straight to the result. Free: digit-serial subtract, then divide.
// One request in flight: a new request is taken only after the last result has moved to the output
// register; a result waits in an output register while the receiver stalls.
// Synchronous active-low reset restores register defaults and refills the stack at once.
`include "descriptor_slot_allocator_assert.svh"
module descriptor_slot_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsa_pkg::ADDR_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [dsa_pkg::ADDR_W-1:0]   in_cpu_addr_in,
  input  logic [dsa_pkg::ADDR_W-1:0]   in_gpu_addr_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dsa_pkg::ADDR_W-1:0]   out_cpu_addr_out,
  output logic [dsa_pkg::ADDR_W-1:0]   out_gpu_addr_out,
  output logic [dsa_pkg::IDX_W-1:0]    out_slot_index,
  output logic [dsa_pkg::STATUS_W-1:0] out_status
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_PREP  = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_CHECK = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Configuration
  logic [dsa_pkg::ADDR_W-1:0] cpu_base_r, cpu_base_nxt;
  logic [dsa_pkg::ADDR_W-1:0] gpu_base_r, gpu_base_nxt;
  logic [dsa_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [dsa_pkg::CNT_W-1:0]  n_r, n_nxt;

  // Stack bookkeeping
  logic [dsa_pkg::CNT_W-1:0]  fc_r, fc_nxt;
  logic [dsa_pkg::CNT_W-1:0]  lw_r, lw_nxt;

  // Sequencer
  state_t                     state_r, state_nxt;
  logic [dsa_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       op_r, op_nxt;
  logic                       use_mem_r, use_mem_nxt;
  logic [dsa_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  dsa_pkg::status_t           status_r, status_nxt;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic [dsa_pkg::ADDR_W-1:0] out_cpu_r, out_cpu_nxt;
  logic [dsa_pkg::ADDR_W-1:0] out_gpu_r, out_gpu_nxt;
  logic [dsa_pkg::IDX_W-1:0]  out_idx_r, out_idx_nxt;
  dsa_pkg::status_t           out_status_r, out_status_nxt;

  // Datapath
  logic                       in_accept;
  logic                       cnt_last;
  logic                       out_free;
  logic [dsa_pkg::STEP_W-1:0] eff_step;
  logic [dsa_pkg::PROD_W-1:0] prod;
  logic [dsa_pkg::CNT_W-1:0]  cfg_count;
  dsa_pkg::lane_ctl_t         add_ctl;
  dsa_pkg::lane_ctl_t         div_ctl;
  logic [dsa_pkg::ADDR_W-1:0] cpu_a, cpu_b, gpu_a, gpu_b;
  logic                       add_cin;
  logic [dsa_pkg::ADDR_W-1:0] cpu_sum, gpu_sum;
  logic [dsa_pkg::ADDR_W-1:0] cpu_quot, gpu_quot;
  logic                       ram_we, ram_re;
  logic [dsa_pkg::IDX_W-1:0]  ram_waddr, ram_raddr, ram_wdata, ram_rdata;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cnt_last  = (cnt_r == dsa_pkg::DCNT_W'(dsa_pkg::NUM_DIGITS - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign eff_step  = (step_r == '0) ? dsa_pkg::STEP_W'(1) : step_r;
  assign prod      = dsa_pkg::PROD_W'(idx_r) * dsa_pkg::PROD_W'(eff_step);

  // Saturate a written slot count to the stack depth
  assign cfg_count = (32'(cfg_wdata[dsa_pkg::SLOT_COUNT_W-1:0]) > dsa_pkg::MAX_SLOTS)
                   ? dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS)
                   : dsa_pkg::CNT_W'(cfg_wdata[dsa_pkg::SLOT_COUNT_W-1:0]);

  // Adder lanes: subtract base on free, add base to index times step on allocate
  assign add_ctl.load = (in_accept && (in_op == dsa_pkg::OP_FREE)) || (state_r == S_MUL);
  assign add_ctl.run  = (state_r == S_ADD);
  assign div_ctl.load = (state_r == S_PREP);
  assign div_ctl.run  = (state_r == S_DIV);

  always_comb begin
    if (state_r == S_MUL) begin
      cpu_a   = cpu_base_r;
      gpu_a   = gpu_base_r;
      cpu_b   = dsa_pkg::ADDR_W'(prod);
      gpu_b   = dsa_pkg::ADDR_W'(prod);
      add_cin = 1'b0;
    end else begin
      cpu_a   = in_cpu_addr_in;
      gpu_a   = in_gpu_addr_in;
      cpu_b   = ~cpu_base_r;
      gpu_b   = ~gpu_base_r;
      add_cin = 1'b1;
    end
  end

  dsa_addsub u_cpu_add (
    .clk     (clk),
    .ctl     (add_ctl),
    .a_in    (cpu_a),
    .b_in    (cpu_b),
    .cin     (add_cin),
    .sum_out (cpu_sum)
  );

  dsa_addsub u_gpu_add (
    .clk     (clk),
    .ctl     (add_ctl),
    .a_in    (gpu_a),
    .b_in    (gpu_b),
    .cin     (add_cin),
    .sum_out (gpu_sum)
  );

  dsa_div u_cpu_div (
    .clk         (clk),
    .ctl         (div_ctl),
    .dividend_in (cpu_sum),
    .divisor     (eff_step),
    .quot_out    (cpu_quot)
  );

  dsa_div u_gpu_div (
    .clk         (clk),
    .ctl         (div_ctl),
    .dividend_in (gpu_sum),
    .divisor     (eff_step),
    .quot_out    (gpu_quot)
  );

  dsa_ram #(
    .WIDTH (dsa_pkg::IDX_W),
    .DEPTH (dsa_pkg::MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, stack pointer, low-water mark and configuration
  always_comb begin
    cpu_base_nxt   = cpu_base_r;
    gpu_base_nxt   = gpu_base_r;
    step_nxt       = step_r;
    n_nxt          = n_r;
    fc_nxt         = fc_r;
    lw_nxt         = lw_r;
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    use_mem_nxt    = use_mem_r;
    idx_nxt        = idx_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_cpu_nxt    = out_cpu_r;
    out_gpu_nxt    = out_gpu_r;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = fc_r[dsa_pkg::IDX_W-1:0];
    ram_wdata      = cpu_quot[dsa_pkg::IDX_W-1:0];
    ram_re         = 1'b0;
    ram_raddr      = dsa_pkg::IDX_W'(fc_r - 1'b1);

    // Drop the output once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt     = in_op;
          cnt_nxt    = '0;
          status_nxt = dsa_pkg::ST_OK;
          if (in_op == dsa_pkg::OP_ALLOC) begin
            if (fc_r == '0) begin
              status_nxt = dsa_pkg::ST_EMPTY;
              idx_nxt    = '0;
              state_nxt  = S_DONE;
            end else begin
              // Entries below the low-water mark still hold their refill value
              use_mem_nxt = (fc_r > lw_r);
              idx_nxt     = dsa_pkg::IDX_W'(n_r - fc_r);
              if (fc_r <= lw_r) begin
                lw_nxt = fc_r - 1'b1;
              end
              ram_re    = 1'b1;
              fc_nxt    = fc_r - 1'b1;
              state_nxt = S_READ;
            end
          end else begin
            state_nxt = S_ADD;
          end
        end
      end
      S_READ: begin
        if (use_mem_r) begin
          idx_nxt = ram_rdata;
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cnt_nxt   = '0;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = (op_r == dsa_pkg::OP_FREE) ? S_PREP : S_DONE;
        end
      end
      S_PREP: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_nxt = '0;
        priority if (cpu_quot != gpu_quot) begin
          status_nxt = dsa_pkg::ST_MISMATCH;
        end else if (cpu_quot >= dsa_pkg::ADDR_W'(n_r)) begin
          status_nxt = dsa_pkg::ST_RANGE;
        end else if (fc_r >= n_r) begin
          status_nxt = dsa_pkg::ST_FULL;
        end else begin
          // Push the freed index
          status_nxt = dsa_pkg::ST_OK;
          ram_we     = 1'b1;
          fc_nxt     = fc_r + 1'b1;
          idx_nxt    = cpu_quot[dsa_pkg::IDX_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register when it is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = idx_r;
          out_status_nxt = status_r;
          if ((op_r == dsa_pkg::OP_ALLOC) && (status_r == dsa_pkg::ST_OK)) begin
            out_cpu_nxt = cpu_sum;
            out_gpu_nxt = gpu_sum;
          end else begin
            out_cpu_nxt = '0;
            out_gpu_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Configuration writes; a slot count write refills the stack
    if (cfg_we) begin
      unique case (dsa_pkg::cfg_reg_t'(cfg_index))
        dsa_pkg::CFG_CPU_BASE:   cpu_base_nxt = cfg_wdata;
        dsa_pkg::CFG_GPU_BASE:   gpu_base_nxt = cfg_wdata;
        dsa_pkg::CFG_SLOT_STEP:  step_nxt     = cfg_wdata[dsa_pkg::STEP_W-1:0];
        dsa_pkg::CFG_SLOT_COUNT: begin
          n_nxt  = cfg_count;
          fc_nxt = cfg_count;
          lw_nxt = cfg_count;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_base_r   <= '0;
      gpu_base_r   <= '0;
      step_r       <= dsa_pkg::STEP_RESET;
      n_r          <= dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS);
      fc_r         <= dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS);
      lw_r         <= dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS);
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      op_r         <= dsa_pkg::OP_ALLOC;
      use_mem_r    <= 1'b0;
      status_r     <= dsa_pkg::ST_OK;
      out_valid_r  <= 1'b0;
      out_status_r <= dsa_pkg::ST_OK;
    end else begin
      cpu_base_r   <= cpu_base_nxt;
      gpu_base_r   <= gpu_base_nxt;
      step_r       <= step_nxt;
      n_r          <= n_nxt;
      fc_r         <= fc_nxt;
      lw_r         <= lw_nxt;
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      op_r         <= op_nxt;
      use_mem_r    <= use_mem_nxt;
      status_r     <= status_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    out_cpu_r <= out_cpu_nxt;
    out_gpu_r <= out_gpu_nxt;
    out_idx_r <= out_idx_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_cpu_addr_out = out_cpu_r;
  assign out_gpu_addr_out = out_gpu_r;
  assign out_slot_index   = out_idx_r;
  assign out_status       = out_status_r;

  `DSA_ASSERT_IMP(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `DSA_ASSERT_IMP(a_stack_order, clk, rst_n, 1'b1, (lw_r <= fc_r) && (fc_r <= n_r))
  `DSA_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_r != S_IDLE)
  `DSA_ASSERT_NXT(a_push_count, clk, rst_n, ram_we && !cfg_we, fc_r == $past(fc_r) + 1'b1)
  `DSA_ASSERT_NXT(a_done_out, clk, rst_n, (state_r == S_DONE) && !out_stall, out_valid)

endmodule

@@ src/dsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module dsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/dsa_addsub.sv @@
// Digit-serial 64-bit adder lane, least significant digit first
module dsa_addsub (
  input  logic                       clk,
  input  dsa_pkg::lane_ctl_t         ctl,
  input  logic [dsa_pkg::ADDR_W-1:0] a_in,
  input  logic [dsa_pkg::ADDR_W-1:0] b_in,
  input  logic                       cin,
  output logic [dsa_pkg::ADDR_W-1:0] sum_out
);

  logic [dsa_pkg::ADDR_W-1:0]  a_r, a_nxt;
  logic [dsa_pkg::ADDR_W-1:0]  b_r, b_nxt;
  logic [dsa_pkg::ADDR_W-1:0]  sum_r, sum_nxt;
  logic                        carry_r, carry_nxt;
  logic [dsa_pkg::DIGIT_W:0]   digit;

  // Add the low digits of both operands plus carry
  assign digit = {1'b0, a_r[dsa_pkg::DIGIT_W-1:0]} + {1'b0, b_r[dsa_pkg::DIGIT_W-1:0]}
               + {{dsa_pkg::DIGIT_W{1'b0}}, carry_r};

  // Load operands or advance one digit
  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    sum_nxt   = sum_r;
    carry_nxt = carry_r;
    if (ctl.load) begin
      a_nxt     = a_in;
      b_nxt     = b_in;
      carry_nxt = cin;
    end else if (ctl.run) begin
      a_nxt     = a_r >> dsa_pkg::DIGIT_W;
      b_nxt     = b_r >> dsa_pkg::DIGIT_W;
      sum_nxt   = {digit[dsa_pkg::DIGIT_W-1:0], sum_r[dsa_pkg::ADDR_W-1:dsa_pkg::DIGIT_W]};
      carry_nxt = digit[dsa_pkg::DIGIT_W];
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    sum_r   <= sum_nxt;
    carry_r <= carry_nxt;
  end

  assign sum_out = sum_r;

endmodule

@@ src/dsa_div.sv @@
// Digit-serial restoring divider lane, one quotient digit per cycle while run is set
module dsa_div (
  input  logic                       clk,
  input  dsa_pkg::lane_ctl_t         ctl,
  input  logic [dsa_pkg::ADDR_W-1:0] dividend_in,
  input  logic [dsa_pkg::STEP_W-1:0] divisor,
  output logic [dsa_pkg::ADDR_W-1:0] quot_out
);

  // Dividend shifts out at the top while quotient digits shift in at the bottom
  logic [dsa_pkg::ADDR_W-1:0]  dq_r, dq_nxt;
  logic [dsa_pkg::STEP_W-1:0]  rem_r, rem_nxt;
  logic [dsa_pkg::STEP_W-1:0]  rem_v;
  logic [dsa_pkg::STEP_W:0]    trial;
  logic [dsa_pkg::DIGIT_W-1:0] qd;

  // Four restoring steps on the narrow remainder
  always_comb begin
    rem_v = rem_r;
    trial = '0;
    qd    = '0;
    for (int k = 0; k < dsa_pkg::DIGIT_W; k++) begin
      trial = {rem_v, dq_r[dsa_pkg::ADDR_W-1-k]};
      if (trial >= {1'b0, divisor}) begin
        rem_v                       = dsa_pkg::STEP_W'(trial - {1'b0, divisor});
        qd[dsa_pkg::DIGIT_W-1-k]    = 1'b1;
      end else begin
        rem_v                       = trial[dsa_pkg::STEP_W-1:0];
        qd[dsa_pkg::DIGIT_W-1-k]    = 1'b0;
      end
    end
  end

  // Load dividend or advance one digit
  always_comb begin
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    if (ctl.load) begin
      dq_nxt  = dividend_in;
      rem_nxt = '0;
    end else if (ctl.run) begin
      dq_nxt  = {dq_r[dsa_pkg::ADDR_W-dsa_pkg::DIGIT_W-1:0], qd};
      rem_nxt = rem_v;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
  end

  assign quot_out = dq_r;

endmodule

@@ bench/descriptor_slot_allocator_checker.sv @@
// Checker for the descriptor slot allocator: predicts each grant and compares it with the outputs
`timescale 1ns / 1ps
module descriptor_slot_allocator_checker
  import dsa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [ADDR_W-1:0]       cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_op,
  input  logic [ADDR_W-1:0]       in_cpu_addr_in,
  input  logic [ADDR_W-1:0]       in_gpu_addr_in,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [ADDR_W-1:0]       out_cpu_addr_out,
  input  logic [ADDR_W-1:0]       out_gpu_addr_out,
  input  logic [IDX_W-1:0]        out_slot_index,
  input  logic [STATUS_W-1:0]     out_status,
  output int                      fail_count,
  output int                      pending,
  output int                      n_ok,
  output int                      n_empty,
  output int                      n_mismatch,
  output int                      n_range,
  output int                      n_full
);

  typedef struct packed {
    logic [ADDR_W-1:0]   cpu;
    logic [ADDR_W-1:0]   gpu;
    logic [IDX_W-1:0]    idx;
    logic [STATUS_W-1:0] status;
  } slot_grant_t;

  // Mirror of the allocator state and registers
  logic [ADDR_W-1:0]       cpu_base_q;
  logic [ADDR_W-1:0]       gpu_base_q;
  logic [STEP_W-1:0]       step_q;
  logic [SLOT_COUNT_W-1:0] count_q;
  logic [IDX_W-1:0]        free_pool [MAX_SLOTS];
  logic [CNT_W-1:0]        pool_depth;

  slot_grant_t expected_grants [$];

  function automatic logic [CNT_W-1:0] live_slots();
    return (count_q > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(count_q);
  endfunction

  // Refill the pool so that slot 0 sits on top
  function void restock_pool();
    logic [CNT_W-1:0] n;
    n = live_slots();
    for (int i = 0; i < int'(n); i++) free_pool[i] = IDX_W'(int'(n) - 1 - i);
    pool_depth = n;
  endfunction

  // Work out the grant for one request and advance the pool
  function void grant_for(input logic op, input logic [ADDR_W-1:0] ca, ga,
                          output slot_grant_t g);
    logic [ADDR_W-1:0] stride, ci, gi;
    logic [CNT_W-1:0]  lim;
    logic [IDX_W-1:0]  slot;
    stride = (step_q == '0) ? ADDR_W'(1) : ADDR_W'(step_q);
    lim    = live_slots();
    g      = '0;
    g.status = ST_OK;
    if (op == OP_ALLOC) begin
      if (pool_depth == '0) begin
        g.status = ST_EMPTY;
      end else begin
        slot       = free_pool[pool_depth - 1'b1];
        pool_depth = pool_depth - 1'b1;
        g.cpu      = cpu_base_q + ADDR_W'(slot) * stride;
        g.gpu      = gpu_base_q + ADDR_W'(slot) * stride;
        g.idx      = slot;
      end
    end else begin
      ci = (ca - cpu_base_q) / stride;
      gi = (ga - gpu_base_q) / stride;
      if (ci != gi) begin
        g.status = ST_MISMATCH;
      end else if (ci >= ADDR_W'(lim)) begin
        g.status = ST_RANGE;
      end else if (pool_depth >= lim) begin
        g.status = ST_FULL;
      end else begin
        free_pool[pool_depth] = ci[IDX_W-1:0];
        pool_depth            = pool_depth + 1'b1;
        g.idx                 = ci[IDX_W-1:0];
      end
    end
  endfunction

  always @(posedge clk) begin : monitor
    slot_grant_t got, want;
    if (!rst_n) begin
      cpu_base_q = '0;
      gpu_base_q = '0;
      step_q     = STEP_RESET;
      count_q    = SLOT_COUNT_W'(MAX_SLOTS);
      restock_pool();
      expected_grants.delete();
      fail_count = 0;
      n_ok       = 0;
      n_empty    = 0;
      n_mismatch = 0;
      n_range    = 0;
      n_full     = 0;
    end else begin
      // Compare a delivered grant with the oldest prediction
      if (out_valid && !out_stall) begin
        got = {out_cpu_addr_out, out_gpu_addr_out, out_slot_index, out_status};
        if (expected_grants.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected grant: cpu %h gpu %h slot %0d status %0d",
                     got.cpu, got.gpu, got.idx, got.status);
        end else begin
          want = expected_grants.pop_front();
          case (want.status)
            ST_OK:       n_ok++;
            ST_EMPTY:    n_empty++;
            ST_MISMATCH: n_mismatch++;
            ST_RANGE:    n_range++;
            default:     n_full++;
          endcase
          if (got.cpu !== want.cpu || got.gpu !== want.gpu ||
              got.idx !== want.idx || got.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("grant mismatch: expected cpu %h gpu %h slot %0d status %0d, %s",
                       want.cpu, want.gpu, want.idx, want.status, "got");
            if (fail_count <= 10)
              $display("                 got      cpu %h gpu %h slot %0d status %0d",
                       got.cpu, got.gpu, got.idx, got.status);
          end
        end
      end
      // Predict the grant for an accepted request
      if (in_valid && !in_stall) begin
        grant_for(in_op, in_cpu_addr_in, in_gpu_addr_in, want);
        expected_grants.insert(expected_grants.size(), want);
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_CPU_BASE:  cpu_base_q = cfg_wdata;
          CFG_GPU_BASE:  gpu_base_q = cfg_wdata;
          CFG_SLOT_STEP: step_q     = cfg_wdata[STEP_W-1:0];
          default: begin
            count_q = cfg_wdata[SLOT_COUNT_W-1:0];
            restock_pool();
          end
        endcase
      end
    end
    pending = expected_grants.size();
  end

endmodule

@@ bench/descriptor_slot_allocator_tb.sv @@
// Testbench top for the descriptor slot allocator: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module descriptor_slot_allocator_tb;
  import dsa_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [ADDR_W-1:0]       cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_op;
  logic [ADDR_W-1:0]       in_cpu_addr_in;
  logic [ADDR_W-1:0]       in_gpu_addr_in;
  logic                    out_valid;
  logic                    out_stall;
  logic [ADDR_W-1:0]       out_cpu_addr_out;
  logic [ADDR_W-1:0]       out_gpu_addr_out;
  logic [IDX_W-1:0]        out_slot_index;
  logic [STATUS_W-1:0]     out_status;

  int fail_count, pending, n_ok, n_empty, n_mismatch, n_range, n_full;

  // Stimulus bookkeeping and a copy of the registers as written
  int                      burst_left;
  int                      sent;
  int                      settings_used;
  int                      hold_seq;
  logic [ADDR_W-1:0]       cpu_base_m;
  logic [ADDR_W-1:0]       gpu_base_m;
  logic [STEP_W-1:0]       step_m;
  logic [SLOT_COUNT_W-1:0] count_m;

  descriptor_slot_allocator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_cpu_addr_in   (in_cpu_addr_in),
    .in_gpu_addr_in   (in_gpu_addr_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cpu_addr_out (out_cpu_addr_out),
    .out_gpu_addr_out (out_gpu_addr_out),
    .out_slot_index   (out_slot_index),
    .out_status       (out_status)
  );

  descriptor_slot_allocator_checker grant_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_cpu_addr_in   (in_cpu_addr_in),
    .in_gpu_addr_in   (in_gpu_addr_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cpu_addr_out (out_cpu_addr_out),
    .out_gpu_addr_out (out_gpu_addr_out),
    .out_slot_index   (out_slot_index),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .pending          (pending),
    .n_ok             (n_ok),
    .n_empty          (n_empty),
    .n_mismatch       (n_mismatch),
    .n_range          (n_range),
    .n_full           (n_full)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up after a generous fixed time
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] stride_now();
    return (step_m == '0) ? ADDR_W'(1) : ADDR_W'(step_m);
  endfunction

  // Offer one request, with burst pacing, and hold it until accepted
  task issue(input logic op, input logic [ADDR_W-1:0] ca, ga);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid       <= 1'b0;
        in_op          <= 1'($urandom);
        in_cpu_addr_in <= rand64();
        in_gpu_addr_in <= rand64();
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_cpu_addr_in <= ca;
    in_gpu_addr_in <= ga;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Free request built from slot numbers, each address with a random offset inside its slot
  task free_pair(input logic [ADDR_W-1:0] kc, kg);
    logic [ADDR_W-1:0] s;
    s = stride_now();
    issue(OP_FREE,
          cpu_base_m + kc * s + ADDR_W'($urandom_range(0, int'(s) - 1)),
          gpu_base_m + kg * s + ADDR_W'($urandom_range(0, int'(s) - 1)));
  endtask

  // Stop offering and wait until every grant has come back
  task settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    burst_left = 0;
  endtask

  task write_reg(input cfg_reg_t r, input logic [ADDR_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= rand64();
    case (r)
      CFG_CPU_BASE:  cpu_base_m = v;
      CFG_GPU_BASE:  gpu_base_m = v;
      CFG_SLOT_STEP: step_m     = v[STEP_W-1:0];
      default:       count_m    = v[SLOT_COUNT_W-1:0];
    endcase
  endtask

  // Drain, then load a full register set (the count write refills the pool)
  task configure(input logic [ADDR_W-1:0] cb, gb, input int st, cn);
    settle();
    write_reg(CFG_CPU_BASE, cb);
    write_reg(CFG_GPU_BASE, gb);
    write_reg(CFG_SLOT_STEP, ADDR_W'(st));
    write_reg(CFG_SLOT_COUNT, ADDR_W'(cn));
    settings_used++;
  endtask

  // Mostly well-formed allocate/free traffic, with some broken frees and noise
  task random_request(input int alloc_pct);
    int                roll, n;
    logic [ADDR_W-1:0] k;
    roll = $urandom_range(0, 99);
    n    = (count_m > MAX_SLOTS) ? MAX_SLOTS : int'(count_m);
    k    = (n == 0) ? '0 : ADDR_W'($urandom_range(0, n - 1));
    if (roll < alloc_pct) begin
      issue(OP_ALLOC, rand64(), rand64());
    end else if (roll < 92) begin
      free_pair(k, k);
    end else if (roll < 95) begin
      free_pair(k, k + ADDR_W'($urandom_range(1, 3)));
    end else if (roll < 98) begin
      k = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom) : ADDR_W'(n + $urandom_range(0, 2));
      free_pair(k, k);
    end else begin
      issue(OP_FREE, rand64(), rand64());
    end
  endtask

  // Receiver: stall patterns of its own, plus a long hold-off on request
  initial begin : receiver
    int mode, span, held, tick;
    out_stall = 1'b0;
    held      = 0;
    tick      = 0;
    forever begin
      if (hold_seq != held) begin
        held = hold_seq;
        repeat (300) @(negedge clk) out_stall <= 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 60);
        repeat (span) begin
          @(negedge clk);
          tick++;
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (tick % 3 == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int slots, st;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_CPU_BASE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_op          = OP_ALLOC;
    in_cpu_addr_in = '0;
    in_gpu_addr_in = '0;
    cpu_base_m     = '0;
    gpu_base_m     = '0;
    step_m         = STEP_RESET;
    count_m        = SLOT_COUNT_W'(MAX_SLOTS);
    burst_left     = 0;
    sent           = 0;
    settings_used  = 1;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Reset defaults: slots come out from 0, truncating frees, full pool, bad frees
    issue(OP_ALLOC, '0, '0);
    issue(OP_ALLOC, '1, '1);
    issue(OP_FREE, 64'd37, 64'd63);
    issue(OP_FREE, '0, '0);
    issue(OP_FREE, 64'd32, 64'd32);
    issue(OP_FREE, '1, '1);
    issue(OP_FREE, '0, 64'd32);
    issue(OP_FREE, '1, '0);

    // Zero step acts as one, addresses wrap, empty pool, double free, full pool
    configure('1, 64'h8000_0000_0000_0000, 0, 2);
    issue(OP_ALLOC, '0, '0);
    issue(OP_ALLOC, '0, '0);
    issue(OP_ALLOC, '1, '1);
    free_pair(1, 1);
    free_pair(1, 1);
    free_pair(0, 0);
    issue(OP_ALLOC, '0, '0);

    // Widest step, count above the slot limit saturates
    configure('0, '1, 8191, 2047);
    issue(OP_ALLOC, '0, '0);
    free_pair(1023, 1023);
    free_pair(1024, 1024);
    issue(OP_ALLOC, '0, '0);

    // No slots at all
    configure(rand64(), rand64(), 4096, 0);
    issue(OP_ALLOC, '0, '0);
    free_pair(0, 0);

    // A single slot
    configure(rand64(), rand64(), 4096, 1);
    issue(OP_ALLOC, '0, '0);
    issue(OP_ALLOC, '0, '0);
    free_pair(0, 0);
    free_pair(0, 0);

    // Random phases over a spread of register settings
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       slots = 8;
        1:       slots = 1024;
        2:       slots = 5;
        3:       slots = 2047;
        4:       slots = 16;
        5:       slots = 1;
        6:       slots = 64;
        7:       slots = 3;
        8:       slots = 700;
        default: slots = 24;
      endcase
      case (p % 5)
        0:       st = $urandom_range(1, 4096);
        1:       st = 1;
        2:       st = 0;
        3:       st = 8191;
        default: st = $urandom_range(0, 8191);
      endcase
      if (p == 3)
        configure('1, '0, st, slots);
      else if (p == 7)
        configure('0, '1, st, slots);
      else
        configure(rand64(), rand64(), st, slots);
      // Hold the receiver off while requests keep coming, so the block backs up
      if (p == 2 || p == 6) hold_seq <= hold_seq + 1;
      repeat (110) random_request((p % 2 == 1) ? 65 : 50);
    end

    settle();
    repeat (40) @(negedge clk);
    $display("Coverage: %0d requests under %0d register settings, long receiver hold-offs: %0d",
             sent, settings_used, hold_seq);
    $display("Grants by status: ok %0d, empty %0d, mismatch %0d, out of range %0d, full %0d",
             n_ok, n_empty, n_mismatch, n_range, n_full);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
